// File: hdl/mi3_pkg.sv
`default_nettype none
package mi3_pkg;

  localparam int IN_FRAC_BITS  = 8;
  localparam int OUT_FRAC_BITS = 16;
  localparam int QSHIFT        = IN_FRAC_BITS + OUT_FRAC_BITS;
  localparam int ELEM_W        = 16;
  localparam int COF_W         = 2 * ELEM_W;
  localparam int DETP_W        = ELEM_W + COF_W;
  localparam int DET_W         = DETP_W + 2;
  localparam int DIV_W         = DETP_W;
  localparam int OUT_W         = 32;
  localparam int QW            = COF_W + QSHIFT;
  localparam int NLANE         = 9;
  // cofactor stages, sign prep, divider stages, output register
  localparam int LATENCY       = 4 + 1 + QW + 1;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [COF_W-1:0]  cof_t;
  typedef logic signed [DET_W-1:0]  det_t;
  typedef logic signed [OUT_W-1:0]  res_t;

  typedef struct packed {
    elem_t in_r0c0;
    elem_t in_r0c1;
    elem_t in_r0c2;
    elem_t in_r1c0;
    elem_t in_r1c1;
    elem_t in_r1c2;
    elem_t in_r2c0;
    elem_t in_r2c1;
    elem_t in_r2c2;
  } in_t;

  typedef struct packed {
    res_t out_r0c0;
    res_t out_r0c1;
    res_t out_r0c2;
    res_t out_r1c0;
    res_t out_r1c1;
    res_t out_r1c2;
    res_t out_r2c0;
    res_t out_r2c1;
    res_t out_r2c2;
    logic singular;
  } out_t;

  typedef struct packed {
    logic                vld;
    cof_t [NLANE-1:0]    cof;
    det_t                det;
  } cof_out_t;

  typedef struct packed {
    logic                      vld;
    logic                      sing;
    logic [NLANE-1:0]          neg;
    logic [NLANE-1:0][QW-1:0]  q;
  } div_out_t;

endpackage
`default_nettype wire

// File: hdl/mi3_cof.sv
`default_nettype none
module mi3_cof (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          vld_in,
  input  wire mi3_pkg::in_t  mat,
  output mi3_pkg::cof_out_t  res
);

  logic                   vld1_r, vld2_r, vld3_r, vld4_r;
  mi3_pkg::cof_t          p_r [18];
  mi3_pkg::elem_t         a00_1_r, a01_1_r, a02_1_r;
  mi3_pkg::elem_t         a00_2_r, a01_2_r, a02_2_r;
  mi3_pkg::cof_t [8:0]    cof2_r, cof3_r, cof4_r;
  logic signed [mi3_pkg::DETP_W-1:0] dp_r [3];
  mi3_pkg::det_t          det4_r;

  // valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else begin
      vld1_r <= vld_in;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  // stage 1: the 2x2 products
  always_ff @(posedge clk) begin
    p_r[0]  <= mat.in_r1c1 * mat.in_r2c2;
    p_r[1]  <= mat.in_r2c1 * mat.in_r1c2;
    p_r[2]  <= mat.in_r0c2 * mat.in_r2c1;
    p_r[3]  <= mat.in_r0c1 * mat.in_r2c2;
    p_r[4]  <= mat.in_r0c1 * mat.in_r1c2;
    p_r[5]  <= mat.in_r0c2 * mat.in_r1c1;
    p_r[6]  <= mat.in_r1c2 * mat.in_r2c0;
    p_r[7]  <= mat.in_r1c0 * mat.in_r2c2;
    p_r[8]  <= mat.in_r0c0 * mat.in_r2c2;
    p_r[9]  <= mat.in_r0c2 * mat.in_r2c0;
    p_r[10] <= mat.in_r1c0 * mat.in_r0c2;
    p_r[11] <= mat.in_r0c0 * mat.in_r1c2;
    p_r[12] <= mat.in_r1c0 * mat.in_r2c1;
    p_r[13] <= mat.in_r2c0 * mat.in_r1c1;
    p_r[14] <= mat.in_r2c0 * mat.in_r0c1;
    p_r[15] <= mat.in_r0c0 * mat.in_r2c1;
    p_r[16] <= mat.in_r0c0 * mat.in_r1c1;
    p_r[17] <= mat.in_r1c0 * mat.in_r0c1;
    a00_1_r <= mat.in_r0c0;
    a01_1_r <= mat.in_r0c1;
    a02_1_r <= mat.in_r0c2;
  end

  // stage 2: cofactors, the difference always fits 32 bits
  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      cof2_r[k] <= p_r[2*k] - p_r[2*k+1];
    end
    a00_2_r <= a00_1_r;
    a01_2_r <= a01_1_r;
    a02_2_r <= a02_1_r;
  end

  // stage 3: first-row terms of the determinant
  always_ff @(posedge clk) begin
    dp_r[0] <= a00_2_r * cof2_r[0];
    dp_r[1] <= a01_2_r * cof2_r[3];
    dp_r[2] <= a02_2_r * cof2_r[6];
    cof3_r  <= cof2_r;
  end

  // stage 4: determinant sum
  always_ff @(posedge clk) begin
    det4_r <= mi3_pkg::DET_W'(dp_r[0]) + mi3_pkg::DET_W'(dp_r[1])
            + mi3_pkg::DET_W'(dp_r[2]);
    cof4_r <= cof3_r;
  end

  assign res.vld = vld4_r;
  assign res.cof = cof4_r;
  assign res.det = det4_r;

endmodule
`default_nettype wire

// File: hdl/mi3_div.sv
`default_nettype none
module mi3_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mi3_pkg::cof_out_t src,
  output mi3_pkg::div_out_t      res
);

  localparam int QW = mi3_pkg::QW;
  localparam int DW = mi3_pkg::DIV_W;
  localparam int NL = mi3_pkg::NLANE;

  logic                       vld_r  [QW+1];
  logic                       sing_r [QW+1];
  logic [NL-1:0]              neg_r  [QW+1];
  logic [DW-1:0]              d_r    [QW+1];
  logic [mi3_pkg::COF_W-1:0]  n_r    [QW+1][NL];
  logic [DW-1:0]              rem_r  [QW+1][NL];
  logic [QW-1:0]              q_r    [QW+1][NL];
  logic                       nbit   [QW][NL];
  logic [mi3_pkg::DET_W-1:0]  det_abs;

  // prep: magnitudes and result signs
  always_comb begin
    det_abs = src.det[mi3_pkg::DET_W-1] ? mi3_pkg::DET_W'(-src.det)
                                         : mi3_pkg::DET_W'(src.det);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= src.vld;
    end
  end

  always_ff @(posedge clk) begin
    sing_r[0] <= (src.det == '0);
    d_r[0]    <= det_abs[DW-1:0];
    for (int l = 0; l < NL; l++) begin
      neg_r[0][l] <= src.cof[l][mi3_pkg::COF_W-1] ^ src.det[mi3_pkg::DET_W-1];
      n_r[0][l]   <= src.cof[l][mi3_pkg::COF_W-1] ? mi3_pkg::COF_W'(-src.cof[l])
                                                  : mi3_pkg::COF_W'(src.cof[l]);
      rem_r[0][l] <= '0;
      q_r[0][l]   <= '0;
    end
  end

  // one quotient bit per stage, restoring division
  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;

    if (B >= mi3_pkg::QSHIFT) begin : g_num
      always_comb begin
        for (int l = 0; l < NL; l++) nbit[s][l] = n_r[s][l][B-mi3_pkg::QSHIFT];
      end
    end else begin : g_zero
      always_comb begin
        for (int l = 0; l < NL; l++) nbit[s][l] = 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else begin
        vld_r[s+1] <= vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      logic [DW:0]   rs;
      logic [DW+1:0] diff;
      sing_r[s+1] <= sing_r[s];
      neg_r[s+1]  <= neg_r[s];
      d_r[s+1]    <= d_r[s];
      for (int l = 0; l < NL; l++) begin
        rs   = {rem_r[s][l], nbit[s][l]};
        diff = {1'b0, rs} - {2'b00, d_r[s]};
        rem_r[s+1][l] <= diff[DW+1] ? rs[DW-1:0] : diff[DW-1:0];
        q_r[s+1][l]   <= {q_r[s][l][QW-2:0], ~diff[DW+1]};
        n_r[s+1][l]   <= n_r[s][l];
      end
    end
  end

  always_comb begin
    res.vld  = vld_r[QW];
    res.sing = sing_r[QW];
    res.neg  = neg_r[QW];
    for (int l = 0; l < NL; l++) res.q[l] = q_r[QW][l];
  end

  // lane 0 remainder stays below divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[QW] && !sing_r[QW] |-> rem_r[QW][0] < d_r[QW])
    else $error("divider remainder not below divisor");

endmodule
`default_nettype wire

// File: hdl/matrix3x3_inverse_top.sv
// 3x3 matrix inverse by the adjugate method, Q8.8 in, Q16.16 out. One matrix
// may be started in every cycle (busy is always low); each result appears
// exactly LATENCY = 62 cycles after its start, for one cycle with out_valid,
// and must be taken then since the block cannot hold results. The latency is
// set by four cofactor/determinant stages, one sign stage, a 56-stage
// one-bit-per-stage divider for all nine elements, and the output register.
// A zero determinant gives all-zero elements with singular set.
`default_nettype none
module matrix3x3_inverse_top (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire mi3_pkg::in_t  in_data,
  output logic               out_valid,
  output mi3_pkg::out_t      out_data
);

  mi3_pkg::cof_out_t cof;
  mi3_pkg::div_out_t div;
  mi3_pkg::res_t     el [mi3_pkg::NLANE];
  logic              out_valid_r;
  mi3_pkg::out_t     out_data_r;

  assign busy = 1'b0;

  mi3_cof u_cof (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_in (start & ~busy),
    .mat    (in_data),
    .res    (cof)
  );

  mi3_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .src   (cof),
    .res   (div)
  );

  // saturate and apply sign
  always_comb begin
    logic [mi3_pkg::QW-1:0] lim;
    logic [mi3_pkg::QW-1:0] mag;
    for (int l = 0; l < mi3_pkg::NLANE; l++) begin
      lim = div.neg[l] ? mi3_pkg::QW'(33'h080000000) : mi3_pkg::QW'(33'h07fffffff);
      mag = (div.q[l] > lim) ? lim : div.q[l];
      if (div.sing) begin
        el[l] = '0;
      end else if (div.neg[l]) begin
        el[l] = mi3_pkg::OUT_W'(-mag[mi3_pkg::OUT_W-1:0]);
      end else begin
        el[l] = mag[mi3_pkg::OUT_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= div.vld;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r.out_r0c0 <= el[0];
    out_data_r.out_r0c1 <= el[1];
    out_data_r.out_r0c2 <= el[2];
    out_data_r.out_r1c0 <= el[3];
    out_data_r.out_r1c1 <= el[4];
    out_data_r.out_r1c2 <= el[5];
    out_data_r.out_r2c0 <= el[6];
    out_data_r.out_r2c1 <= el[7];
    out_data_r.out_r2c2 <= el[8];
    out_data_r.singular <= div.sing;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // singular transaction carries zero diagonal elements
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.singular |->
      out_data.out_r0c0 == '0 && out_data.out_r1c1 == '0 && out_data.out_r2c2 == '0)
    else $error("singular result with nonzero elements");

  // result strobe comes in the cycle after the divider output
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(div.vld))
    else $error("result strobe without divider transaction");

  // positive lane 0 quotient never wraps negative
  a_sat_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.singular && !$past(div.neg[0]) |->
      !out_data.out_r0c0[mi3_pkg::OUT_W-1])
    else $error("positive element saturated to negative");

endmodule
`default_nettype wire
